@@ sv/binary_to_decimal_ascii_core_macros.svh @@
// Assertion macros used by the checker of the decimal text converter.
`ifndef BINARY_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BD2A_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BD2A_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/bd2a_pkg.sv @@
// Package with word types and constants of the decimal text converter.
package bd2a_pkg;

	localparam int VALUE_W       = 64;
	localparam int CHAR_W        = 6;
	localparam int DIGITS        = 20;
	localparam int BCD_W         = 4 * DIGITS;
	localparam int BITS_PER_STEP = 2;
	localparam int STEPS         = VALUE_W / BITS_PER_STEP;
	localparam int STEP_CNT_W    = $clog2(STEPS);
	localparam int DIG_CNT_W     = $clog2(DIGITS + 1);

	localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
	localparam logic [CHAR_W-1:0] CH_NINE  = 6'd57;
	localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               is_signed;
	} num_word_t;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
	} chr_word_t;

endpackage

@@ sv/binary_to_decimal_ascii_core.sv @@
// Converter of one 64-bit number, signed or unsigned, to its decimal ASCII text. A number is
// taken only while the core is idle; its magnitude then goes through the shift-and-add-3 unit,
// two bits a cycle. The digits are then read out most significant first: leading zeros are
// skipped one by one, and each character waits at the output register while it is stalled.
// A negative signed number is preceded by a minus sign. Zero gives the single character '0'.
// The final character of a number carries last. The output register holds the final
// character while the next number is already taken.
module binary_to_decimal_ascii_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                num_valid,
	output logic                num_stall,
	input  bd2a_pkg::num_word_t num,
	output logic                chr_valid,
	input  logic                chr_stall,
	output bd2a_pkg::chr_word_t chr
);
	import bd2a_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]            state_q;
	logic [VALUE_W-1:0]    bin_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [STEP_CNT_W-1:0] step_q;
	logic [DIG_CNT_W-1:0]  dig_left_q;
	logic                  sign_pend_q;
	logic                  started_q;
	logic                  chr_valid_q;
	chr_word_t             chr_q;

	logic [BCD_W-1:0]   bcd_next;
	logic [VALUE_W-1:0] bin_next;
	logic               num_fire;
	logic               out_free;
	logic               skip;
	logic               emit_fire;
	logic [3:0]         top_digit;
	logic               neg;

	bd2a_dabble_step u_step (
		.bcd      (bcd_q),
		.bin      (bin_q),
		.bcd_next (bcd_next),
		.bin_next (bin_next)
	);

	assign num_stall = (state_q != ST_IDLE);
	assign num_fire  = num_valid && !num_stall;
	assign neg       = num.is_signed && num.value[VALUE_W-1];
	assign top_digit = bcd_q[BCD_W-1 -: 4];
	assign out_free  = !chr_valid_q || !chr_stall;
	// Leading zeros are dropped, but the units digit is always sent.
	assign skip      = (state_q == ST_EMIT) && !sign_pend_q && !started_q &&
		(top_digit == 4'd0) && (dig_left_q > DIG_CNT_W'(1));
	assign emit_fire = (state_q == ST_EMIT) && out_free && !skip;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			dig_left_q  <= '0;
			sign_pend_q <= 1'b0;
			started_q   <= 1'b0;
			chr_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				chr_valid_q <= emit_fire;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (num_fire) begin
						state_q     <= ST_CONV;
						step_q      <= '0;
						sign_pend_q <= neg;
						started_q   <= 1'b0;
					end
				end
				ST_CONV: begin
					step_q <= step_q + STEP_CNT_W'(1);
					if (step_q == STEP_CNT_W'(STEPS - 1)) begin
						state_q    <= ST_EMIT;
						dig_left_q <= DIG_CNT_W'(DIGITS);
					end
				end
				ST_EMIT: begin
					if (skip) begin
						dig_left_q <= dig_left_q - DIG_CNT_W'(1);
					end else if (emit_fire) begin
						if (sign_pend_q) begin
							sign_pend_q <= 1'b0;
						end else begin
							started_q  <= 1'b1;
							dig_left_q <= dig_left_q - DIG_CNT_W'(1);
							if (dig_left_q == DIG_CNT_W'(1)) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (num_fire) begin
			bin_q <= neg ? (~num.value + VALUE_W'(1)) : num.value;
			bcd_q <= '0;
		end else if (state_q == ST_CONV) begin
			bin_q <= bin_next;
			bcd_q <= bcd_next;
		end else if (skip || (emit_fire && !sign_pend_q)) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
		end
		if (emit_fire) begin
			if (sign_pend_q) begin
				chr_q.character <= CH_MINUS;
				chr_q.last      <= 1'b0;
			end else begin
				chr_q.character <= CH_ZERO + {2'b00, top_digit};
				chr_q.last      <= (dig_left_q == DIG_CNT_W'(1));
			end
		end
	end

	assign chr_valid = chr_valid_q;
	assign chr       = chr_q;

endmodule

@@ sv/bd2a_dabble_step.sv @@
// Shift-and-add-3 unit: moves BITS_PER_STEP binary bits into the BCD digits.
module bd2a_dabble_step (
	input  logic [bd2a_pkg::BCD_W-1:0]   bcd,
	input  logic [bd2a_pkg::VALUE_W-1:0] bin,
	output logic [bd2a_pkg::BCD_W-1:0]   bcd_next,
	output logic [bd2a_pkg::VALUE_W-1:0] bin_next
);
	import bd2a_pkg::*;

	always_comb begin
		logic [BCD_W-1:0]   b;
		logic [VALUE_W-1:0] r;
		b = bcd;
		r = bin;
		for (int s = 0; s < BITS_PER_STEP; s++) begin
			// Each digit of five or more is raised by three so that doubling carries into the next.
			for (int d = 0; d < DIGITS; d++) begin
				if (b[4*d +: 4] >= 4'd5) begin
					b[4*d +: 4] = b[4*d +: 4] + 4'd3;
				end
			end
			b = {b[BCD_W-2:0], r[VALUE_W-1]};
			r = {r[VALUE_W-2:0], 1'b0};
		end
		bcd_next = b;
		bin_next = r;
	end

endmodule

@@ sv/bd2a_checker.sv @@
// Port checker of the decimal text converter and its binding to the converter core.
`include "binary_to_decimal_ascii_core_macros.svh"

module bd2a_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                num_valid,
	input logic                num_stall,
	input logic                chr_valid,
	input logic                chr_stall,
	input bd2a_pkg::chr_word_t chr
);
	import bd2a_pkg::*;

	logic chr_held;
	logic chr_minus;
	logic chr_legal;

	assign chr_held  = chr_valid && chr_stall;
	assign chr_minus = chr_valid && (chr.character == CH_MINUS);
	assign chr_legal = (chr.character == CH_MINUS) ||
		((chr.character >= CH_ZERO) && (chr.character <= CH_NINE));

	`BD2A_ASSERT_NEXT(a_chr_hold, chr_held, chr_valid && $stable(chr), "stalled word changed")
	`BD2A_ASSERT_NEXT(a_busy_after_take, num_valid && !num_stall, num_stall, "idle after a take")
	`BD2A_ASSERT_SAME(a_minus_not_last, chr_minus, !chr.last, "sign marked last")
	`BD2A_ASSERT_SAME(a_char_range, chr_valid, chr_legal, "bad character")

endmodule

bind binary_to_decimal_ascii_core bd2a_checker u_bd2a_checker (.*);

@@ dv/binary_to_decimal_ascii_core_tb.sv @@
// Self-checking testbench of the 64-bit binary to decimal ASCII text converter.
module binary_to_decimal_ascii_core_tb;
	import bd2a_pkg::*;

	localparam int IDLE_PCT   = 12;
	localparam int HOLD_LEN   = 300;
	localparam int TAIL_WAIT  = 60;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      num_valid = 1'b0;
	logic      num_stall;
	num_word_t num = '0;
	logic      chr_valid;
	logic      chr_stall = 1'b0;
	chr_word_t chr;

	chr_word_t expected_chars[$];
	int        mismatches = 0;
	bit        gaps_on = 1'b0;
	bit        long_hold_req = 1'b0;
	int        hold_left = 0;

	binary_to_decimal_ascii_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.num_valid (num_valid),
		.num_stall (num_stall),
		.num       (num),
		.chr_valid (chr_valid),
		.chr_stall (chr_stall),
		.chr       (chr)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#1_000_000;
		$display("Mismatches found");
		$finish;
	end

	// Expected text of one number: optional minus, then digits most significant first.
	task automatic predict_text(input num_word_t w);
		logic [VALUE_W-1:0] mag;
		logic               negative;
		chr_word_t          text[$];
		chr_word_t          c;
		negative = w.is_signed && w.value[VALUE_W-1];
		mag = negative ? (~w.value + 64'd1) : w.value;
		c.last = 1'b0;
		do begin
			c.character = CH_ZERO + CHAR_W'(mag % 64'd10);
			text.push_front(c);
			mag = mag / 64'd10;
		end while (mag != 0);
		if (negative) begin
			c.character = CH_MINUS;
			text.push_front(c);
		end
		text[text.size() - 1].last = 1'b1;
		foreach (text[i])
			expected_chars.push_back(text[i]);
	endtask

	// Offers one number and returns at the edge where it is taken.
	task automatic send_number(input logic [VALUE_W-1:0] v, input logic s);
		num_word_t w;
		w.value = v;
		w.is_signed = s;
		while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
			num_valid <= 1'b0;
			@(posedge clk);
		end
		num_valid <= 1'b1;
		num <= w;
		@(posedge clk);
		while (num_stall)
			@(posedge clk);
		predict_text(w);
	endtask

	task automatic drain;
		num_valid <= 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
	endtask

	// Random values of several shapes so that every text length shows up.
	function automatic logic [VALUE_W-1:0] pick_value(input int unsigned shape);
		logic [VALUE_W-1:0] v;
		int unsigned        k;
		v = {$urandom, $urandom};
		case (shape)
			1: begin
				v = v >> $urandom_range(63);
			end
			2: begin
				k = $urandom_range(19);
				v = 64'd1;
				repeat (k)
					v = v * 64'd10;
				v = v + 64'($urandom_range(2)) - 64'd1;
			end
			3: begin
				v = ~(v >> $urandom_range(63, 40)) + 64'd1;
			end
			default: begin
			end
		endcase
		return v;
	endfunction

	// Receiver side: random stalls, or one long hold-off when asked for.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			chr_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_left = HOLD_LEN - 1;
			chr_stall <= 1'b1;
		end else begin
			chr_stall <= gaps_on && ($urandom_range(99) < IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		chr_word_t want;
		if (arst_n && chr_valid && !chr_stall) begin
			if (expected_chars.size() == 0) begin
				$error("character: expected none, actual %0d", chr.character);
				mismatches++;
			end else begin
				want = expected_chars.pop_front();
				if (chr.character !== want.character) begin
					$error("character: expected %0d, actual %0d",
						want.character, chr.character);
					mismatches++;
				end
				if (chr.last !== want.last) begin
					$error("last: expected %0d, actual %0d", want.last, chr.last);
					mismatches++;
				end
			end
		end
	end

	task automatic test_extremes;
		gaps_on = 1'b0;
		send_number(64'd0, 1'b0);
		send_number(64'd0, 1'b1);
		send_number(64'd1, 1'b0);
		send_number(64'd1, 1'b1);
		send_number({64{1'b1}}, 1'b1);
		send_number({64{1'b1}}, 1'b0);
		send_number(64'h8000_0000_0000_0000, 1'b1);
		send_number(64'h8000_0000_0000_0000, 1'b0);
		send_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
		send_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
		send_number(64'd9, 1'b0);
		send_number(64'd10, 1'b1);
		send_number(64'd99, 1'b0);
		send_number(64'd100, 1'b1);
		send_number(64'd9999999999999999999, 1'b0);
		send_number(64'd10000000000000000000, 1'b0);
		send_number(~64'd9, 1'b1);
		send_number(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
		send_number(64'h5555_5555_5555_5555, 1'b1);
		drain();
	endtask

	task automatic test_digit_lengths;
		gaps_on = 1'b1;
		repeat (100)
			send_number(pick_value($urandom_range(3)), 1'($urandom));
		drain();
	endtask

	// Back to back on both sides for a long stretch.
	task automatic test_full_range_no_gaps;
		gaps_on = 1'b0;
		repeat (80)
			send_number(pick_value(0), 1'($urandom));
		drain();
	endtask

	task automatic test_backpressure;
		gaps_on = 1'b0;
		long_hold_req = 1'b1;
		repeat (12)
			send_number(pick_value($urandom_range(1, 3)), 1'($urandom));
		drain();
	endtask

	task automatic test_random_mix;
		gaps_on = 1'b1;
		repeat (100)
			send_number(pick_value($urandom_range(3)), 1'($urandom));
		drain();
	endtask

	initial begin
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_digit_lengths();
		test_full_range_no_gaps();
		test_backpressure();
		test_random_mix();
		repeat (TAIL_WAIT)
			@(posedge clk);
		if (expected_chars.size() != 0) begin
			$error("character: expected %0d more words, actual none", expected_chars.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
